// File: sv/tlaik_pkg.sv
// Shared constants, types and the CORDIC angle table for the two-link arm solver.
`timescale 1ns / 1ps

package tlaik_pkg;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int HEIGHT_W   = 13;
    localparam int BASE_W     = 12;
    localparam int LEN_W      = 11;

    // Datapath widths. They follow from the register widths: a reachable
    // target lies within 4094 units of the shoulder in each axis.
    localparam int EXT_W  = 14;   // ex, ey of a reachable target
    localparam int DEN_W  = 23;   // 2 * L1 * L2
    localparam int NUM_W  = 25;   // elbow cosine numerator, |num| <= den
    localparam int RAD_W  = 46;   // den^2 - num^2
    localparam int SQ_W   = 23;   // floor(sqrt(den^2 - num^2))
    localparam int K_W    = 37;   // L1 * den + L2 * num
    localparam int KE_W   = 51;   // K * ex, K * ey
    localparam int Q_W    = 35;   // L2 * S, signed
    localparam int QE_W   = 49;   // L2 * S * ex, L2 * S * ey
    localparam int AW     = 52;   // shoulder atan2 operands
    localparam int EL_W   = 26;   // elbow atan2 operands

    // Angles in degrees with 20 fraction bits.
    localparam int ZW       = 30;
    localparam int CW       = 33;
    localparam int INT_FRAC = 20;
    localparam int TAB_LEN  = 24;

    localparam logic signed [ZW-1:0] HALF_TURN = ZW'(180 * (2 ** INT_FRAC));

    // atan(2^-i) in degrees, 20 fraction bits.
    localparam logic [ZW-1:0] ATAN_TAB [TAB_LEN] = '{
        30'd47185920, 30'd27855475, 30'd14718068, 30'd7471121,
        30'd3750058,  30'd1876857,  30'd938658,   30'd469357,
        30'd234682,   30'd117342,   30'd58671,    30'd29335,
        30'd14668,    30'd7334,     30'd3667,     30'd1833,
        30'd917,      30'd458,      30'd229,      30'd115,
        30'd57,       30'd29,       30'd14,       30'd7
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEIGHT    = 3'd0,
        CFG_BASE_X    = 3'd1,
        CFG_BASE_Y    = 3'd2,
        CFG_UPPER_LEN = 3'd3,
        CFG_LOWER_LEN = 3'd4
    } cfg_index_t;

    // Values that ride along the square-root pipeline.
    typedef struct packed {
        logic                    reach;
        logic signed [EXT_W-1:0] ex;
        logic signed [EXT_W-1:0] ey;
        logic signed [K_W-1:0]   k;
        logic signed [NUM_W-1:0] num;
    } sq_side_t;

endpackage

// File: sv/tlaik_atan2.sv
// Pipelined CORDIC atan2 in degrees, one operand pair per cycle while en is high.
`timescale 1ns / 1ps

module tlaik_atan2 #(
    parameter int IN_W  = 52,
    parameter int STEPS = 16
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [IN_W-1:0]        y_in,
    input  logic signed [IN_W-1:0]        x_in,
    output logic signed [tlaik_pkg::ZW-1:0] z_out
);
    import tlaik_pkg::*;

    localparam int SH_W = $clog2(IN_W + 1);
    localparam int PW   = (IN_W > 30) ? IN_W : 30;

    logic [IN_W-1:0] ax_a_reg, ay_a_reg;
    logic            xneg_a_reg, yneg_a_reg;

    logic [IN_W-1:0] ax_b_reg, ay_b_reg, or_a;
    logic [SH_W-1:0] sh_b_reg, sh_next;
    logic            xneg_b_reg, yneg_b_reg, zero_b_reg;

    logic [PW-1:0] sx, sy;

    logic signed [CW-1:0] cx_reg [STEPS+1];
    logic signed [CW-1:0] cy_reg [STEPS+1];
    logic signed [ZW-1:0] z_reg  [STEPS+1];
    logic                 xneg_reg [STEPS+1];
    logic                 yneg_reg [STEPS+1];
    logic                 zero_reg [STEPS+1];

    logic signed [CW-1:0] cx_next [STEPS];
    logic signed [CW-1:0] cy_next [STEPS];
    logic signed [ZW-1:0] z_next  [STEPS];

    logic signed [ZW-1:0] zq;

    // Shift that brings both magnitudes below 2^30.
    assign or_a = ax_a_reg | ay_a_reg;

    always_comb
    begin
        sh_next = '0;
        for (int i = 30; i < IN_W; i++)
        begin
            if (or_a[i])
            begin
                sh_next = SH_W'(i - 29);
            end
        end
    end

    assign sx = PW'(ax_b_reg) >> sh_b_reg;
    assign sy = PW'(ay_b_reg) >> sh_b_reg;

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic up;
        assign up = !cy_reg[k][CW-1];
        assign cx_next[k] = up ? cx_reg[k] + (cy_reg[k] >>> k) : cx_reg[k] - (cy_reg[k] >>> k);
        assign cy_next[k] = up ? cy_reg[k] - (cx_reg[k] >>> k) : cy_reg[k] + (cx_reg[k] >>> k);
        assign z_next[k]  = up ? z_reg[k] + $signed(ATAN_TAB[k])
                               : z_reg[k] - $signed(ATAN_TAB[k]);
    end

    assign zq = xneg_reg[STEPS] ? HALF_TURN - z_reg[STEPS] : z_reg[STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_a_reg   <= x_in[IN_W-1] ? $unsigned(-x_in) : $unsigned(x_in);
            ay_a_reg   <= y_in[IN_W-1] ? $unsigned(-y_in) : $unsigned(y_in);
            xneg_a_reg <= x_in[IN_W-1];
            yneg_a_reg <= y_in[IN_W-1];

            ax_b_reg   <= ax_a_reg;
            ay_b_reg   <= ay_a_reg;
            sh_b_reg   <= sh_next;
            xneg_b_reg <= xneg_a_reg;
            yneg_b_reg <= yneg_a_reg;
            zero_b_reg <= (or_a == '0);

            cx_reg[0]   <= $signed({3'b000, sx[29:0]});
            cy_reg[0]   <= $signed({3'b000, sy[29:0]});
            z_reg[0]    <= '0;
            xneg_reg[0] <= xneg_b_reg;
            yneg_reg[0] <= yneg_b_reg;
            zero_reg[0] <= zero_b_reg;

            for (int k = 0; k < STEPS; k++)
            begin
                cx_reg[k+1]   <= cx_next[k];
                cy_reg[k+1]   <= cy_next[k];
                z_reg[k+1]    <= z_next[k];
                xneg_reg[k+1] <= xneg_reg[k];
                yneg_reg[k+1] <= yneg_reg[k];
                zero_reg[k+1] <= zero_reg[k];
            end

            if (zero_reg[STEPS])
            begin
                z_out <= '0;
            end
            else
            begin
                z_out <= yneg_reg[STEPS] ? -zq : zq;
            end
        end
    end

endmodule

// File: sv/two_link_arm_inverse_kinematics.sv
// Top level of the two-link planar arm inverse kinematics solver.
`timescale 1ns / 1ps

// The block takes one target point per clock in screen pixels, flips Y
// against the screen height, moves the origin to the shoulder, and solves
// the two-link arm by the law of cosines. Each result gives a reachable flag
// and the shoulder and elbow angles in degrees with ANGLE_FRAC_BITS fraction
// bits; an unreachable target (or a zero segment length) gives zero angles.
// Throughput is one target per cycle while the output is not stalled. From
// an input transfer to its result, a target passes through the stages of
// squares and products, a bit-per-stage square root, the products that
// build the shoulder atan2 operands, the two CORDIC atan2 pipelines that
// run side by side, and the output register. The whole pipeline holds
// while a finished result is stalled at the output; in_stall follows
// out_stall in the same cycle, so a result and a new target can both
// transfer on one edge. Configuration writes are always taken (cfg_ready
// is tied high) and must only be issued while the pipeline is empty.
// Register indices beyond the list are ignored.

module two_link_arm_inverse_kinematics #(
    parameter int COORD_BITS      = 12,
    parameter int ANGLE_FRAC_BITS = 7,
    parameter int CORDIC_STEPS    = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [COORD_BITS-1:0]                target_x,
    input  logic [COORD_BITS-1:0]                target_y,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 reachable,
    output logic signed [15:0]                   shoulder_angle,
    output logic [14:0]                          elbow_angle,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tlaik_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tlaik_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tlaik_pkg::*;

    // Offsets can reach past the coordinate range by the shoulder position
    // and the screen height.
    localparam int EW       = ((COORD_BITS > 13) ? COORD_BITS : 13) + 2;
    localparam int NW       = 2 * EW + 1;
    localparam int ATAN_LAT = CORDIC_STEPS + 4;
    localparam int RSH      = INT_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [ZW:0] DEG_HI = (ZW+1)'(180 * (2 ** ANGLE_FRAC_BITS));
    localparam logic signed [ZW:0] DEG_LO = -DEG_HI;
    localparam logic signed [ZW:0] RND    = (ZW+1)'(2 ** (RSH - 1));

    // Configuration registers.
    logic [HEIGHT_W-1:0]      screen_height_reg;
    logic signed [BASE_W-1:0] base_x_reg;
    logic signed [BASE_W-1:0] base_y_reg;
    logic [LEN_W-1:0]         upper_length_reg;
    logic [LEN_W-1:0]         lower_length_reg;

    // A single enable moves every stage; it drops only when a result
    // sits in the output register and the consumer stalls.
    logic en;

    // Stage 1: offsets from the shoulder.
    logic signed [EW-1:0] s1_ex_reg, s1_ey_reg;
    // Stage 2: squares and the cosine denominator.
    logic signed [2*EW-1:0] s2_exsq_reg, s2_eysq_reg;
    logic [2*LEN_W-1:0]     s2_l1sq_reg, s2_l2sq_reg;
    logic [DEN_W-1:0]       s2_den_reg;
    logic signed [EXT_W-1:0] s2_ex_reg, s2_ey_reg;
    // Stage 3: cosine numerator.
    logic signed [NW-1:0]   s3_num_reg;
    logic [DEN_W-1:0]       s3_den_reg;
    logic signed [EXT_W-1:0] s3_ex_reg, s3_ey_reg;
    // Stage 4: reachability.
    logic                    s4_reach_reg;
    logic signed [NUM_W-1:0] s4_num_reg;
    logic [DEN_W-1:0]        s4_den_reg;
    logic signed [EXT_W-1:0] s4_ex_reg, s4_ey_reg;
    // Stage 5: products for the radicand and K.
    logic [RAD_W-1:0]        s5_densq_reg, s5_numsq_reg;
    logic [LEN_W+DEN_W-1:0]  s5_l1den_reg;
    logic signed [K_W-1:0]   s5_l2num_reg;
    logic                    s5_reach_reg;
    logic signed [NUM_W-1:0] s5_num_reg;
    logic signed [EXT_W-1:0] s5_ex_reg, s5_ey_reg;
    logic signed [2*NUM_W-1:0] num_sq;

    // Square root pipeline; index 0 is loaded from stage 5.
    logic [RAD_W-1:0]  sq_rad_reg  [SQ_W+1];
    logic [SQ_W-1:0]   sq_root_reg [SQ_W+1];
    logic [SQ_W+2:0]   sq_rem_reg  [SQ_W+1];
    sq_side_t          sq_side_reg [SQ_W+1];
    logic [SQ_W+2:0]   sq_rem_next [SQ_W];
    logic              sq_ge       [SQ_W];

    // Shoulder operand products.
    logic [Q_W-2:0]           q_mag;
    logic signed [KE_W-1:0]   m1_ke_reg, m1_kx_reg, m2_ke_reg, m2_kx_reg;
    logic signed [Q_W-1:0]    m1_q_reg;
    logic signed [QE_W-1:0]   m2_qx_reg, m2_qy_reg;
    logic signed [AW-1:0]     m3_sy_reg, m3_sx_reg;
    logic [SQ_W-1:0]          m1_s_reg, m2_s_reg, m3_s_reg;
    logic signed [NUM_W-1:0]  m1_num_reg, m2_num_reg, m3_num_reg;
    logic signed [EXT_W-1:0]  m1_ex_reg, m1_ey_reg;
    logic                     m1_reach_reg, m2_reach_reg, m3_reach_reg;

    // Valid bits of every stage.
    logic                v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [SQ_W:0]       sq_v_reg;
    logic                m1_v_reg, m2_v_reg, m3_v_reg;
    logic [ATAN_LAT-1:0] at_v_reg;
    logic [ATAN_LAT-1:0] at_reach_reg;

    logic signed [ZW-1:0] sh_z, el_z;
    logic signed [ZW:0]   sh_deg, el_deg;

    logic                 out_valid_reg;
    logic                 reachable_reg;
    logic signed [15:0]   shoulder_angle_reg;
    logic [14:0]          elbow_angle_reg;

    // Rounds half up from 20 fraction bits and clamps to the angle range.
    function automatic logic signed [ZW:0] to_deg(input logic signed [ZW-1:0] z,
                                                  input logic signed [ZW:0]   lo);
        logic signed [ZW:0] r;
        r = ($signed({z[ZW-1], z}) + RND) >>> RSH;
        if (r > DEG_HI)
        begin
            r = DEG_HI;
        end
        if (r < lo)
        begin
            r = lo;
        end
        return r;
    endfunction

    assign en        = !out_valid_reg || !out_stall;
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_height_reg <= HEIGHT_W'(600);
            base_x_reg        <= '0;
            base_y_reg        <= '0;
            upper_length_reg  <= LEN_W'(100);
            lower_length_reg  <= LEN_W'(100);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_HEIGHT:    screen_height_reg <= cfg_data[HEIGHT_W-1:0];
                CFG_BASE_X:    base_x_reg        <= $signed(cfg_data[BASE_W-1:0]);
                CFG_BASE_Y:    base_y_reg        <= $signed(cfg_data[BASE_W-1:0]);
                CFG_UPPER_LEN: upper_length_reg  <= cfg_data[LEN_W-1:0];
                CFG_LOWER_LEN: lower_length_reg  <= cfg_data[LEN_W-1:0];
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Combinational helpers between stages.
    // ------------------------------------------------------------------
    assign num_sq = s4_num_reg * s4_num_reg;

    // One result bit of the square root per stage.
    for (genvar j = 0; j < SQ_W; j++)
    begin : g_sqrt
        logic [SQ_W+2:0] rem_t, trial;
        assign rem_t = {sq_rem_reg[j][SQ_W:0], sq_rad_reg[j][RAD_W-1-2*j -: 2]};
        assign trial = {1'b0, sq_root_reg[j], 2'b01};
        assign sq_ge[j]       = (rem_t >= trial);
        assign sq_rem_next[j] = sq_ge[j] ? rem_t - trial : rem_t;
    end

    assign q_mag = lower_length_reg * sq_root_reg[SQ_W];

    // ------------------------------------------------------------------
    // Valid bits.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            sq_v_reg      <= '0;
            m1_v_reg      <= 1'b0;
            m2_v_reg      <= 1'b0;
            m3_v_reg      <= 1'b0;
            at_v_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            sq_v_reg      <= {sq_v_reg[SQ_W-1:0], v5_reg};
            m1_v_reg      <= sq_v_reg[SQ_W];
            m2_v_reg      <= m1_v_reg;
            m3_v_reg      <= m2_v_reg;
            at_v_reg      <= {at_v_reg[ATAN_LAT-2:0], m3_v_reg};
            out_valid_reg <= at_v_reg[ATAN_LAT-1];
        end
    end

    // ------------------------------------------------------------------
    // Datapath.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Stage 1: flip Y and move the origin to the shoulder.
            s1_ex_reg <= $signed(EW'(target_x)) - EW'(base_x_reg);
            s1_ey_reg <= $signed(EW'(screen_height_reg)) - $signed(EW'(target_y))
                         - EW'(1) - EW'(base_y_reg);

            // Stage 2.
            s2_exsq_reg <= s1_ex_reg * s1_ex_reg;
            s2_eysq_reg <= s1_ey_reg * s1_ey_reg;
            s2_l1sq_reg <= upper_length_reg * upper_length_reg;
            s2_l2sq_reg <= lower_length_reg * lower_length_reg;
            s2_den_reg  <= (DEN_W'(upper_length_reg) * DEN_W'(lower_length_reg)) << 1;
            s2_ex_reg   <= s1_ex_reg[EXT_W-1:0];
            s2_ey_reg   <= s1_ey_reg[EXT_W-1:0];

            // Stage 3.
            s3_num_reg <= NW'(s2_exsq_reg) + NW'(s2_eysq_reg)
                          - $signed(NW'(s2_l1sq_reg)) - $signed(NW'(s2_l2sq_reg));
            s3_den_reg <= s2_den_reg;
            s3_ex_reg  <= s2_ex_reg;
            s3_ey_reg  <= s2_ey_reg;

            // Stage 4: the elbow cosine must lie in -1..1.
            s4_reach_reg <= (s3_den_reg != '0)
                            && (s3_num_reg <= $signed(NW'(s3_den_reg)))
                            && (s3_num_reg >= -$signed(NW'(s3_den_reg)));
            s4_num_reg   <= s3_num_reg[NUM_W-1:0];
            s4_den_reg   <= s3_den_reg;
            s4_ex_reg    <= s3_ex_reg;
            s4_ey_reg    <= s3_ey_reg;

            // Stage 5.
            s5_densq_reg <= s4_den_reg * s4_den_reg;
            s5_numsq_reg <= num_sq[RAD_W-1:0];
            s5_l1den_reg <= upper_length_reg * s4_den_reg;
            s5_l2num_reg <= $signed({1'b0, lower_length_reg}) * s4_num_reg;
            s5_reach_reg <= s4_reach_reg;
            s5_num_reg   <= s4_num_reg;
            s5_ex_reg    <= s4_ex_reg;
            s5_ey_reg    <= s4_ey_reg;

            // Stage 6: radicand (forced to zero when the target is out of
            // reach) and K, the start of the square root pipeline.
            sq_rad_reg[0]  <= s5_reach_reg ? s5_densq_reg - s5_numsq_reg : '0;
            sq_root_reg[0] <= '0;
            sq_rem_reg[0]  <= '0;
            sq_side_reg[0] <= '{
                reach: s5_reach_reg,
                ex:    s5_ex_reg,
                ey:    s5_ey_reg,
                k:     $signed({2'b00, s5_l1den_reg}) + s5_l2num_reg,
                num:   s5_num_reg
            };

            for (int j = 0; j < SQ_W; j++)
            begin
                sq_rad_reg[j+1]  <= sq_rad_reg[j];
                sq_root_reg[j+1] <= {sq_root_reg[j][SQ_W-2:0], sq_ge[j]};
                sq_rem_reg[j+1]  <= sq_rem_next[j];
                sq_side_reg[j+1] <= sq_side_reg[j];
            end

            // Shoulder operands:
            //   sy = K*ey - L2*S*ex,  sx = L2*S*ey + K*ex.
            m1_ke_reg    <= sq_side_reg[SQ_W].k * sq_side_reg[SQ_W].ey;
            m1_kx_reg    <= sq_side_reg[SQ_W].k * sq_side_reg[SQ_W].ex;
            m1_q_reg     <= $signed({1'b0, q_mag});
            m1_s_reg     <= sq_root_reg[SQ_W];
            m1_num_reg   <= sq_side_reg[SQ_W].num;
            m1_ex_reg    <= sq_side_reg[SQ_W].ex;
            m1_ey_reg    <= sq_side_reg[SQ_W].ey;
            m1_reach_reg <= sq_side_reg[SQ_W].reach;

            m2_qx_reg    <= m1_q_reg * m1_ex_reg;
            m2_qy_reg    <= m1_q_reg * m1_ey_reg;
            m2_ke_reg    <= m1_ke_reg;
            m2_kx_reg    <= m1_kx_reg;
            m2_s_reg     <= m1_s_reg;
            m2_num_reg   <= m1_num_reg;
            m2_reach_reg <= m1_reach_reg;

            m3_sy_reg    <= AW'(m2_ke_reg) - AW'(m2_qx_reg);
            m3_sx_reg    <= AW'(m2_qy_reg) + AW'(m2_kx_reg);
            m3_s_reg     <= m2_s_reg;
            m3_num_reg   <= m2_num_reg;
            m3_reach_reg <= m2_reach_reg;

            at_reach_reg <= {at_reach_reg[ATAN_LAT-2:0], m3_reach_reg};

            // Output register; angles are zero for an unreachable target.
            reachable_reg <= at_reach_reg[ATAN_LAT-1];
            if (at_reach_reg[ATAN_LAT-1])
            begin
                shoulder_angle_reg <= sh_deg[15:0];
                elbow_angle_reg    <= el_deg[14:0];
            end
            else
            begin
                shoulder_angle_reg <= '0;
                elbow_angle_reg    <= '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // The two atan2 units run in lockstep.
    // ------------------------------------------------------------------
    tlaik_atan2 #(
        .IN_W  (AW),
        .STEPS (CORDIC_STEPS)
    ) u_shoulder_atan (
        .clk   (clk),
        .en    (en),
        .y_in  (m3_sy_reg),
        .x_in  (m3_sx_reg),
        .z_out (sh_z)
    );

    tlaik_atan2 #(
        .IN_W  (EL_W),
        .STEPS (CORDIC_STEPS)
    ) u_elbow_atan (
        .clk   (clk),
        .en    (en),
        .y_in  ($signed({3'b000, m3_s_reg})),
        .x_in  (EL_W'(m3_num_reg)),
        .z_out (el_z)
    );

    assign sh_deg = to_deg(sh_z, DEG_LO);
    assign el_deg = to_deg(el_z, '0);

    assign out_valid      = out_valid_reg;
    assign reachable      = reachable_reg;
    assign shoulder_angle = shoulder_angle_reg;
    assign elbow_angle    = elbow_angle_reg;

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the two-link arm inverse kinematics solver.
`timescale 1ns / 1ps

// The testbench streams target points through the solver and checks every
// result against a predictor built into this file. The predictor computes
// the same exact integer law of cosines: square root, CORDIC atan2 and
// rounding to degrees with seven fraction bits.
//
// The run is split into phases. Each phase after the first waits until the
// solver is empty, writes all five registers and queues its targets. A
// clocked driver feeds the targets, and a clocked monitor drains and checks
// the results. Most random targets are aimed into the square that bounds
// the arm's reach. The others are spread over the whole screen, so that
// every input bit toggles. The idle patterns change by phase: first the
// receiver idles more, then the sender, and in the last phases neither idles.

module tb_top;

    import tlaik_pkg::*;

    localparam int FRAC_OUT    = 7;
    localparam int STEPS       = 16;
    localparam int LATENCY     = 37 + STEPS;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [11:0] x;
        logic [11:0] y;
    } target_t;

    typedef struct {
        logic               reach;
        logic signed [15:0] shoulder;
        logic [14:0]        elbow;
    } joint_angles_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [11:0] target_x;
    logic [11:0] target_y;
    logic        out_valid;
    logic        out_stall;
    logic        reachable;
    logic signed [15:0] shoulder_angle;
    logic [14:0] elbow_angle;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // This is the testbench's copy of the solver's registers.
    logic [12:0]        arm_height;
    logic signed [11:0] arm_base_x;
    logic signed [11:0] arm_base_y;
    logic [10:0]        arm_len1;
    logic [10:0]        arm_len2;

    target_t       target_queue[$];
    joint_angles_t angle_queue[$];

    int snd_idle;
    int rcv_idle;
    int errors;
    int results_seen;
    int reach_seen;
    int cycles;

    two_link_arm_inverse_kinematics dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .target_x(target_x), .target_y(target_y),
        .out_valid(out_valid), .out_stall(out_stall),
        .reachable(reachable), .shoulder_angle(shoulder_angle),
        .elbow_angle(elbow_angle),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // This function returns the integer square root, found one bit at a time.
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // This function returns atan2 in degrees with 20 fraction bits. CORDIC
    // vectoring runs on the magnitudes, and the quadrant is fixed afterwards.
    function automatic longint atan2_deg(longint yv, longint xv);
        longint unsigned ax;
        longint unsigned ay;
        longint cx;
        longint cy;
        longint dx;
        longint dy;
        longint z;
        ax = (xv < 0) ? longint'(-xv) : longint'(xv);
        ay = (yv < 0) ? longint'(-yv) : longint'(yv);
        if (ax == 0 && ay == 0)
            return 0;
        while (((ax | ay) >> 30) != 0)
        begin
            ax = ax >> 1;
            ay = ay >> 1;
        end
        cx = longint'(ax);
        cy = longint'(ay);
        z = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0)
            begin
                cx = cx + dx;
                cy = cy - dy;
                z = z + longint'(ATAN_TAB[i]);
            end
            else
            begin
                cx = cx - dx;
                cy = cy + dy;
                z = z - longint'(ATAN_TAB[i]);
            end
        end
        if (xv < 0)
            z = (longint'(180) << INT_FRAC) - z;
        if (yv < 0)
            z = -z;
        return z;
    endfunction

    // This function rounds half up to the output fraction and clamps the result.
    function automatic longint round_deg(longint z, longint lo_deg);
        longint r;
        r = (z + (longint'(1) << (INT_FRAC - FRAC_OUT - 1))) >>> (INT_FRAC - FRAC_OUT);
        if (r > (longint'(180) << FRAC_OUT))
            r = longint'(180) << FRAC_OUT;
        if (r < lo_deg * (longint'(1) << FRAC_OUT))
            r = lo_deg * (longint'(1) << FRAC_OUT);
        return r;
    endfunction

    function automatic joint_angles_t solve_arm(logic [11:0] tx, logic [11:0] ty);
        joint_angles_t res;
        longint ex;
        longint ey;
        longint l1;
        longint l2;
        longint den;
        longint num;
        longint s;
        longint k;
        longint sy;
        longint sx;
        ex = longint'(tx) - longint'(arm_base_x);
        ey = longint'(arm_height) - longint'(ty) - 1 - longint'(arm_base_y);
        l1 = longint'(arm_len1);
        l2 = longint'(arm_len2);
        den = 2 * l1 * l2;
        num = ex * ex + ey * ey - l1 * l1 - l2 * l2;
        res.reach = 1'b0;
        res.shoulder = '0;
        res.elbow = '0;
        // A zero segment length or a cosine outside -1..1 gives zero angles.
        if (den == 0 || num > den || num < -den)
            return res;
        s = longint'(int_sqrt(longint'(den * den - num * num)));
        k = l1 * den + l2 * num;
        sy = k * ey - l2 * s * ex;
        sx = l2 * s * ey + k * ex;
        res.reach = 1'b1;
        res.elbow = 15'(round_deg(atan2_deg(s, num), 0));
        res.shoulder = 16'(round_deg(atan2_deg(sy, sx), -180));
        return res;
    endfunction

    // The driver records an expectation when a target transfers. It then
    // presents the next queued target, or idles. A stalled target is held.
    always @(posedge clk or negedge rst_n)
    begin : target_driver
        target_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            target_x <= '0;
            target_y <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                angle_queue.push_back(solve_arm(target_x, target_y));
            if (!(in_valid && in_stall))
            begin
                if (target_queue.size() > 0 && $urandom_range(99) >= snd_idle)
                begin
                    nxt = target_queue.pop_front();
                    in_valid <= 1'b1;
                    target_x <= nxt.x;
                    target_y <= nxt.y;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // The monitor checks each result transfer against the oldest expectation.
    // It also sets the stall for the next cycle.
    always @(posedge clk or negedge rst_n)
    begin : angle_monitor
        joint_angles_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (angle_queue.size() == 0)
                begin
                    $display("%0t: result with no expectation: reach %0b sh %0d el %0d",
                             $time, reachable, shoulder_angle, elbow_angle);
                    errors++;
                end
                else
                begin
                    want = angle_queue.pop_front();
                    if (want.reach)
                        reach_seen++;
                    if (reachable !== want.reach)
                    begin
                        $display("%0t: reachable expected %0b actual %0b",
                                 $time, want.reach, reachable);
                        errors++;
                    end
                    if (shoulder_angle !== want.shoulder)
                    begin
                        $display("%0t: shoulder_angle expected %0d actual %0d",
                                 $time, want.shoulder, shoulder_angle);
                        errors++;
                    end
                    if (elbow_angle !== want.elbow)
                    begin
                        $display("%0t: elbow_angle expected %0d actual %0d",
                                 $time, want.elbow, elbow_angle);
                        errors++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < rcv_idle);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles.", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // The solver is empty once no target is queued, none is being presented,
    // and every expected result has arrived.
    task automatic wait_drained();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (target_queue.size() != 0 || in_valid || angle_queue.size() != 0);
    endtask

    task automatic setup_arm(int h, int bx, int by, int l1, int l2);
        wait_drained();
        arm_height = 13'(h);
        arm_base_x = 12'(bx);
        arm_base_y = 12'(by);
        arm_len1 = 11'(l1);
        arm_len2 = 11'(l2);
        write_reg(CFG_HEIGHT, 13'(h));
        write_reg(CFG_BASE_X, 13'(bx));
        write_reg(CFG_BASE_Y, 13'(by));
        write_reg(CFG_UPPER_LEN, 13'(l1));
        write_reg(CFG_LOWER_LEN, 13'(l2));
    endtask

    task automatic push_target(int x, int y);
        target_t t;
        t.x = 12'(x);
        t.y = 12'(y);
        target_queue.push_back(t);
    endtask

    // Three of four targets are aimed into the square that bounds the arm's
    // reach. A target that falls off the screen is replaced by a random one.
    task automatic queue_targets(int n);
        int reach;
        int ex;
        int ey;
        int tx;
        int ty;
        reach = int'(arm_len1) + int'(arm_len2);
        if (reach == 0)
            reach = 1;
        for (int i = 0; i < n; i++)
        begin
            ex = int'($urandom_range(2 * reach)) - reach;
            ey = int'($urandom_range(2 * reach)) - reach;
            tx = ex + int'(arm_base_x);
            ty = int'(arm_height) - 1 - ey - int'(arm_base_y);
            if ($urandom_range(3) == 0 || tx < 0 || tx > 4095 || ty < 0 || ty > 4095)
                push_target($urandom_range(4095), $urandom_range(4095));
            else
                push_target(tx, ty);
        end
    endtask

    task automatic random_arm();
        setup_arm($urandom_range(1, 4096), int'($urandom_range(4095)) - 2048,
                  int'($urandom_range(4095)) - 2048,
                  $urandom_range(1, 2047), $urandom_range(1, 2047));
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        snd_idle = 28;
        rcv_idle = 51;
        errors = 0;
        results_seen = 0;
        reach_seen = 0;
        cycles = 0;
        arm_height = 13'd600;
        arm_base_x = '0;
        arm_base_y = '0;
        arm_len1 = 11'd100;
        arm_len2 = 11'd100;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // The first targets are directed, and they use the reset settings.
        // They cover the screen corners and a target at the shoulder, where
        // both shoulder atan2 operands are zero. They also cover the fully
        // stretched and fully folded elbow and targets just past the reach.
        push_target(0, 0);
        push_target(4095, 4095);
        push_target(0, 4095);
        push_target(4095, 0);
        push_target(0, 599);
        push_target(200, 599);
        push_target(201, 599);
        push_target(0, 399);
        push_target(0, 398);
        push_target(141, 458);
        push_target(100, 499);
        push_target(150, 599);
        queue_targets(200);

        setup_arm(4096, -2048, -2048, 2047, 2047);
        push_target(0, 4095);
        push_target(2046, 4095);
        queue_targets(200);
        setup_arm(1, 2047, 2047, 1, 1);
        queue_targets(150);

        snd_idle = 51;
        rcv_idle = 28;
        setup_arm(4096, 2047, 0, 2047, 1);
        queue_targets(200);
        // A zero segment length makes every target unreachable.
        setup_arm(600, 0, 0, 0, 100);
        queue_targets(100);
        setup_arm(600, 0, 0, 100, 0);
        queue_targets(50);
        setup_arm(0, 100, -200, 300, 500);
        queue_targets(200);

        snd_idle = 0;
        rcv_idle = 0;
        for (int p = 0; p < 4; p++)
        begin
            random_arm();
            queue_targets(180);
        end
        setup_arm(600, 0, 0, 100, 100);
        queue_targets(50);

        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        if (angle_queue.size() != 0)
        begin
            $display("%0d expected results never arrived.", angle_queue.size());
            errors++;
        end
        $display("Checked %0d solver results, %0d of them reachable, over 12 arm settings.",
                 results_seen, reach_seen);
        $display("Errors found: %0d.", errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
